// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the chained integer calculator.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/cic_pkg.sv -----
// Package for the chained integer calculator: widths, operation and status codes,
// and the request and response payload types. Depends on nothing.
`timescale 1ns / 1ps

package cic_pkg;

    localparam int DATA_W   = 32;
    localparam int TYPE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 6;

    // Operation codes carried in req_type.
    localparam logic [TYPE_W-1:0] OP_LOAD   = 4'd0;
    localparam logic [TYPE_W-1:0] OP_ADD    = 4'd1;
    localparam logic [TYPE_W-1:0] OP_SUB    = 4'd2;
    localparam logic [TYPE_W-1:0] OP_MUL    = 4'd3;
    localparam logic [TYPE_W-1:0] OP_DIV    = 4'd4;
    localparam logic [TYPE_W-1:0] OP_MOD    = 4'd5;
    localparam logic [TYPE_W-1:0] OP_POW    = 4'd6;
    localparam logic [TYPE_W-1:0] OP_FACT   = 4'd7;
    localparam logic [TYPE_W-1:0] OP_EQUALS = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ARITH = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SEQ   = 2'd2;

    // Last step of the bit-serial divider.
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);
    // Smallest n whose factorial wraps to zero at this width.
    localparam logic [DATA_W-1:0] FACT_ZERO_N = DATA_W'(34);
    // First factor of the factorial product.
    localparam logic [CNT_W-1:0] FACT_FIRST = CNT_W'(2);

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic signed [DATA_W-1:0] operand;
    } cic_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic                     finished;
    } cic_rsp_t;

endpackage

// ----- rtl/chained_integer_calculator_top.sv -----
// Chained integer calculator: accumulator, chain flag, sequencer and shared datapath.
// Depends on cic_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Accumulator calculator with 32-bit two's-complement wrap. A request with
// req_type load places the operand in the accumulator and opens a chain; add, sub,
// mul, div, mod and pow then combine the accumulator with the operand, factorial
// replaces the accumulator with its factorial and closes the chain, and equals
// closes the chain. Every request yields exactly one response carrying the new
// accumulator, a status (ok, arithmetic error for a zero divisor or zero to a
// negative power, sequence error for an operator without an open chain or an
// unknown code) and a finished flag. The block handles one request at a time:
// req_ready is high only while the sequencer is idle, and the response sits in an
// output register so the next request can be taken while it waits. The work is
// done on one shared 32x32 multiplier and one shared 32-bit adder: load, add,
// sub, mul, equals and error cases finish in the decode step, div and mod run a
// divisor-magnitude step, the divide loop (one quotient bit per cycle) and a sign
// fix, pow loops one multiply and one square per significant exponent bit, and
// factorial makes one multiply per factor for 1 <= n <= 33, else finishes in the
// decode step; every result then waits in a final step until the output is free.
module chained_integer_calculator_top
    import cic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  cic_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output cic_rsp_t rsp_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_ABS,
        S_DIV,
        S_DIV_FIX,
        S_POW_MUL,
        S_POW_SQR,
        S_FACT,
        S_FIN
    } state_t;

    state_t                state_reg;
    logic [TYPE_W-1:0]     op_reg;
    logic [DATA_W-1:0]     acc_reg;
    logic                  chain_open_reg;
    // Operand, later the divisor magnitude or the remaining exponent.
    logic [DATA_W-1:0]     opnd_reg;
    // Dividend shifting into the quotient, power result or factorial product.
    logic [DATA_W-1:0]     work_reg;
    // Partial remainder, or the running square of the power base.
    logic [DATA_W-1:0]     rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_a_reg;
    logic                  neg_b_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  finished_reg;
    logic                  rsp_valid_reg;
    cic_rsp_t              rsp_reg;

    // Shared adder: add_a + add_b, or add_a - add_b when add_sub is set.
    logic [DATA_W-1:0]     add_a;
    logic [DATA_W-1:0]     add_b;
    logic                  add_sub;
    logic [DATA_W:0]       add_sum;

    // Shared multiplier, low half of the product kept.
    logic [DATA_W-1:0]     mul_a;
    logic [DATA_W-1:0]     mul_b;
    logic [DATA_W-1:0]     mul_p;

    logic [DATA_W-1:0]     rem_shift;
    logic [DATA_W-1:0]     fix_val;
    logic                  fix_neg;
    logic                  rsp_free;

    assign rem_shift = {rem_reg[DATA_W-2:0], work_reg[DATA_W-1]};
    assign fix_val   = (op_reg == OP_DIV) ? work_reg : rem_reg;
    assign fix_neg   = (op_reg == OP_DIV) ? (neg_a_reg ^ neg_b_reg) : neg_a_reg;

    always_comb
    begin
        add_a   = acc_reg;
        add_b   = opnd_reg;
        add_sub = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                if (op_reg == OP_ADD)
                begin
                    add_a   = acc_reg;
                    add_b   = opnd_reg;
                    add_sub = 1'b0;
                end
                else if (op_reg == OP_SUB)
                begin
                    add_a   = acc_reg;
                    add_b   = opnd_reg;
                    add_sub = 1'b1;
                end
                else
                begin
                    // Magnitude of the dividend.
                    add_a   = '0;
                    add_b   = acc_reg;
                    add_sub = 1'b1;
                end
            end
            S_DIV_ABS:
            begin
                add_a   = '0;
                add_b   = opnd_reg;
                add_sub = 1'b1;
            end
            S_DIV:
            begin
                add_a   = rem_shift;
                add_b   = opnd_reg;
                add_sub = 1'b1;
            end
            S_DIV_FIX:
            begin
                add_a   = '0;
                add_b   = fix_val;
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = opnd_reg;
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {DATA_W{add_sub}}}
                     + {{DATA_W{1'b0}}, add_sub};

    always_comb
    begin
        case (state_reg)
            S_POW_MUL:
            begin
                mul_a = work_reg;
                mul_b = rem_reg;
            end
            S_POW_SQR:
            begin
                mul_a = rem_reg;
                mul_b = rem_reg;
            end
            S_FACT:
            begin
                mul_a = work_reg;
                mul_b = {{(DATA_W-CNT_W){1'b0}}, cnt_reg};
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = opnd_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            acc_reg        <= '0;
            chain_open_reg <= 1'b0;
            opnd_reg       <= '0;
            work_reg       <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            neg_a_reg      <= 1'b0;
            neg_b_reg      <= 1'b0;
            status_reg     <= STAT_OK;
            finished_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            // In S_FIN a drained slot is refilled below instead of cleared.
            if (rsp_valid_reg && rsp_ready && state_reg != S_FIN)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg    <= req_data.req_type;
                        opnd_reg  <= req_data.operand;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    status_reg   <= STAT_OK;
                    finished_reg <= 1'b0;
                    state_reg    <= S_FIN;
                    neg_a_reg    <= acc_reg[DATA_W-1];
                    neg_b_reg    <= opnd_reg[DATA_W-1];
                    if (op_reg == OP_LOAD)
                    begin
                        acc_reg        <= opnd_reg;
                        chain_open_reg <= 1'b1;
                    end
                    else if (op_reg > OP_EQUALS)
                    begin
                        status_reg     <= STAT_SEQ;
                        chain_open_reg <= 1'b0;
                    end
                    else if (!chain_open_reg)
                    begin
                        status_reg <= STAT_SEQ;
                    end
                    else
                    begin
                        unique case (op_reg) inside
                            OP_ADD, OP_SUB:
                            begin
                                acc_reg <= add_sum[DATA_W-1:0];
                            end
                            OP_MUL:
                            begin
                                acc_reg <= mul_p;
                            end
                            OP_DIV, OP_MOD:
                            begin
                                if (opnd_reg == '0)
                                begin
                                    status_reg <= STAT_ARITH;
                                end
                                else
                                begin
                                    work_reg  <= acc_reg[DATA_W-1] ? add_sum[DATA_W-1:0]
                                                                   : acc_reg;
                                    rem_reg   <= '0;
                                    cnt_reg   <= '0;
                                    state_reg <= S_DIV_ABS;
                                end
                            end
                            OP_POW:
                            begin
                                if (!opnd_reg[DATA_W-1])
                                begin
                                    work_reg  <= DATA_W'(1);
                                    rem_reg   <= acc_reg;
                                    state_reg <= S_POW_MUL;
                                end
                                else if (acc_reg == DATA_W'(1))
                                begin
                                    acc_reg <= DATA_W'(1);
                                end
                                else if (acc_reg == {DATA_W{1'b1}})
                                begin
                                    // Minus one alternates with the exponent's parity.
                                    acc_reg <= opnd_reg[0] ? {DATA_W{1'b1}} : DATA_W'(1);
                                end
                                else if (acc_reg == '0)
                                begin
                                    status_reg <= STAT_ARITH;
                                end
                                else
                                begin
                                    acc_reg <= '0;
                                end
                            end
                            OP_FACT:
                            begin
                                chain_open_reg <= 1'b0;
                                finished_reg   <= 1'b1;
                                if (acc_reg[DATA_W-1] || acc_reg == '0)
                                begin
                                    acc_reg <= DATA_W'(1);
                                end
                                else if (acc_reg >= FACT_ZERO_N)
                                begin
                                    acc_reg <= '0;
                                end
                                else
                                begin
                                    work_reg  <= DATA_W'(1);
                                    cnt_reg   <= FACT_FIRST;
                                    state_reg <= S_FACT;
                                end
                            end
                            default:
                            begin
                                // Equals.
                                chain_open_reg <= 1'b0;
                                finished_reg   <= 1'b1;
                            end
                        endcase
                    end
                end

                S_DIV_ABS:
                begin
                    if (neg_b_reg)
                    begin
                        opnd_reg <= add_sum[DATA_W-1:0];
                    end
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    // Carry out of the subtraction means the divisor fits.
                    rem_reg  <= add_sum[DATA_W] ? add_sum[DATA_W-1:0] : rem_shift;
                    work_reg <= {work_reg[DATA_W-2:0], add_sum[DATA_W]};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_DIV_FIX;
                    end
                end

                S_DIV_FIX:
                begin
                    acc_reg   <= fix_neg ? add_sum[DATA_W-1:0] : fix_val;
                    state_reg <= S_FIN;
                end

                S_POW_MUL:
                begin
                    if (opnd_reg == '0)
                    begin
                        acc_reg   <= work_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        if (opnd_reg[0])
                        begin
                            work_reg <= mul_p;
                        end
                        state_reg <= S_POW_SQR;
                    end
                end

                S_POW_SQR:
                begin
                    rem_reg   <= mul_p;
                    opnd_reg  <= opnd_reg >> 1;
                    state_reg <= S_POW_MUL;
                end

                S_FACT:
                begin
                    if (cnt_reg > acc_reg[CNT_W-1:0])
                    begin
                        acc_reg   <= work_reg;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        work_reg <= mul_p;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                    end
                end

                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg.value    <= acc_reg;
                        rsp_reg.status   <= status_reg;
                        rsp_reg.finished <= finished_reg;
                        rsp_valid_reg    <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted request always goes straight to the decode step.
    `ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_reg == S_EXEC, "accept did not start decode")
    // The divider never runs with a zero divisor.
    `ASSERT_IMPLIES(a_div_nonzero, state_reg == S_DIV, opnd_reg != '0, "divider running on zero")
    // Factorial has already closed the chain and marked the result finished.
    `ASSERT_IMPLIES(a_fact_closed, state_reg == S_FACT, !chain_open_reg && finished_reg, "factorial left chain open")
    // A finished computation is delivered as soon as the output slot is free.
    `ASSERT_NEXT(a_fin_deliver, state_reg == S_FIN && rsp_free, rsp_valid_reg && state_reg == S_IDLE, "response not delivered")
    // The factorial counter never runs past FACT_ZERO_N, one above the largest looped n.
    `ASSERT_IMPLIES(a_fact_bound, state_reg == S_FACT, cnt_reg <= FACT_ZERO_N[CNT_W-1:0], "factorial counter overrun")

endmodule

// ----- verif/tb_chained_integer_calculator_top.sv -----
// Self-checking testbench for chained_integer_calculator_top: directed and random request
// streams, an in-line accumulator predictor, random idling on both channels.
// Depends on cic_pkg and the calculator RTL.
`timescale 1ns / 1ps

module tb_chained_integer_calculator_top;
    import cic_pkg::*;

    localparam int N_RANDOM_REQS = 1600;
    localparam int SETTLE_CYCLES = 100;  // comfortably above the slowest request (pow)
    localparam int HOLD_CYCLES   = 400;  // receiver hold-off that backs up the block

    localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_1 = {DATA_W{1'b1}};

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    cic_req_t req_data = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    cic_rsp_t rsp_data;

    chained_integer_calculator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Requests still to be sent, and the answers the accumulator model says must come back.
    cic_req_t queued_requests[$];
    cic_rsp_t awaited_answers[$];

    // Shadow copy of the calculator state.
    logic [DATA_W-1:0] shadow_acc = '0;
    logic              shadow_chain_open = 1'b0;

    // Handshake bookkeeping. req_offers counts requests the sender has put on the bus,
    // req_accepts counts those the block has taken; they differ while one is pending.
    int req_offers = 0;
    int req_accepts = 0;
    int total_reqs = 0;
    int answers_seen = 0;
    int fail_count = 0;

    // Coverage tallies for the closing summary.
    int chains_closed = 0;
    int arith_errors = 0;
    int seq_errors = 0;
    int holds_done = 0;

    // Idling state of both sides.
    int send_gap = 0;
    bit quiet_send = 1'b0;
    int recv_stall = 0;
    bit quiet_recv = 1'b0;
    int hold_left = 0;
    int hold_at = 250;

    // Accumulator model: applies one accepted request to the shadow state and
    // returns the answer that request must produce.
    function automatic cic_rsp_t apply_calc_request(cic_req_t req);
        cic_rsp_t          ans;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] prod;
        logic [DATA_W-1:0] n;
        int                k;
        a = shadow_acc;
        b = req.operand;
        ans.status = STAT_OK;
        ans.finished = 1'b0;
        if (req.req_type == OP_LOAD)
        begin
            a = b;
            shadow_chain_open = 1'b1;
        end
        else if (req.req_type > OP_EQUALS)
        begin
            // Unknown code: flagged and the chain is dropped.
            ans.status = STAT_SEQ;
            shadow_chain_open = 1'b0;
        end
        else if (!shadow_chain_open)
        begin
            ans.status = STAT_SEQ;
        end
        else
        begin
            case (req.req_type)
                OP_ADD: a = a + b;
                OP_SUB: a = a - b;
                OP_MUL: a = a * b;
                OP_DIV:
                begin
                    // Dividing by -1 is a plain negate so the most negative value wraps.
                    if (b == '0)
                        ans.status = STAT_ARITH;
                    else if (b == MINUS_1)
                        a = '0 - a;
                    else
                        a = $signed(a) / $signed(b);
                end
                OP_MOD:
                begin
                    if (b == '0)
                        ans.status = STAT_ARITH;
                    else if (b == MINUS_1)
                        a = '0;
                    else
                        a = $signed(a) % $signed(b);
                end
                OP_POW:
                begin
                    if (!b[DATA_W-1])
                    begin
                        // Square and multiply, all products wrapped to the data width.
                        prod = 1;
                        base = a;
                        for (k = 0; k < DATA_W; k++)
                        begin
                            if (b[k])
                                prod = prod * base;
                            base = base * base;
                        end
                        a = prod;
                    end
                    else if (a == 1)
                        a = 1;
                    else if (a == MINUS_1)
                        a = b[0] ? MINUS_1 : DATA_W'(1);
                    else if (a == '0)
                        ans.status = STAT_ARITH;
                    else
                        a = '0;
                end
                OP_FACT:
                begin
                    if ($signed(a) <= 0)
                        a = 1;
                    else
                    begin
                        // Once the wrapped product reaches zero it stays zero.
                        prod = 1;
                        for (n = 2; n <= a && prod != '0; n++)
                            prod = prod * n;
                        a = prod;
                    end
                    shadow_chain_open = 1'b0;
                    ans.finished = 1'b1;
                end
                default:
                begin
                    shadow_chain_open = 1'b0;
                    ans.finished = 1'b1;
                end
            endcase
        end
        shadow_acc = a;
        ans.value = a;
        return ans;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Operand mix: small values, the corner values, and full-range random words.
    function automatic logic [DATA_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return DATA_W'($urandom_range(0, 20)) - DATA_W'(10);
        if (r < 40)
        begin
            case ($urandom_range(0, 5))
                0: return '0;
                1: return DATA_W'(1);
                2: return MINUS_1;
                3: return MAX_POS;
                4: return MIN_NEG;
                default: return DATA_W'(34);
            endcase
        end
        return DATA_W'($urandom());
    endfunction

    function automatic void add_req(logic [TYPE_W-1:0] code, logic [DATA_W-1:0] operand);
        cic_req_t req;
        req.req_type = code;
        req.operand = operand;
        queued_requests.push_back(req);
    endfunction

    task automatic note_mismatch(string what, cic_rsp_t want, cic_rsp_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s: expected value %0d status %0d finished %0d, got value %0d status %0d finished %0d",
                     $time, what, want.value, want.status, want.finished,
                     got.value, got.status, got.finished);
    endtask

    // Request driver. A pending request is held unchanged until the block takes it;
    // the next one follows right away or after a random gap.
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && req_accepts != req_offers))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (queued_requests.size() > 0)
            begin
                req_data <= queued_requests.pop_front();
                req_valid <= 1'b1;
                req_offers++;
                if ($urandom_range(0, 63) == 0)
                    quiet_send = !quiet_send;
                send_gap = quiet_send ? 0 : pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response side. Random stalls, quiet stretches with ready held high, and two long
    // hold-offs during which the sender keeps offering and the block has to back up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (answers_seen >= hold_at)
            begin
                hold_left = HOLD_CYCLES;
                hold_at += 700;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    quiet_recv = !quiet_recv;
                recv_stall = quiet_recv ? 0 : pick_gap();
                rsp_ready <= (recv_stall == 0);
                if (recv_stall > 0)
                    recv_stall--;
            end
        end
    end

    // Monitor: checks the response first, then records any request taken at the same
    // edge, so a response can never be matched against its own request.
    always @(posedge clk)
    begin
        cic_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                answers_seen++;
                if (awaited_answers.size() == 0)
                begin
                    want = '0;
                    note_mismatch("response with no request outstanding", want, rsp_data);
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (rsp_data.value !== want.value || rsp_data.status !== want.status ||
                        rsp_data.finished !== want.finished)
                        note_mismatch("response mismatch", want, rsp_data);
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_calc_request(req_data);
                awaited_answers.push_back(want);
                req_accepts++;
                if (want.finished)
                    chains_closed++;
                if (want.status == STAT_ARITH)
                    arith_errors++;
                if (want.status == STAT_SEQ)
                    seq_errors++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int n_ops;
        int small_n;

        // Directed part: operators without a chain, wrap at both ends, the division
        // corners, negative exponents, factorial edges and unknown codes.
        add_req(OP_EQUALS, '0);
        add_req(OP_ADD, MIN_NEG);
        add_req(OP_LOAD, MAX_POS);
        add_req(OP_ADD, DATA_W'(1));
        add_req(OP_SUB, DATA_W'(1));
        add_req(OP_MUL, MAX_POS);
        add_req(OP_LOAD, MIN_NEG);
        add_req(OP_DIV, MINUS_1);
        add_req(OP_MOD, MINUS_1);
        add_req(OP_DIV, '0);
        add_req(OP_MOD, '0);
        add_req(OP_LOAD, -DATA_W'(7));
        add_req(OP_MOD, DATA_W'(3));
        add_req(OP_FACT, '0);
        add_req(OP_LOAD, '0);
        add_req(OP_POW, MINUS_1);
        add_req(OP_POW, '0);
        add_req(OP_POW, MIN_NEG);
        add_req(OP_LOAD, MINUS_1);
        add_req(OP_POW, -DATA_W'(3));
        add_req(OP_LOAD, DATA_W'(3));
        add_req(OP_POW, MAX_POS);
        add_req(OP_LOAD, DATA_W'(12));
        add_req(OP_FACT, MINUS_1);
        add_req(OP_LOAD, DATA_W'(5));
        add_req(4'd15, MINUS_1);
        add_req(OP_LOAD, DATA_W'(6));
        add_req(OP_EQUALS, MAX_POS);

        // Random part: mostly complete chains with random operands, the rest noise
        // with any code, which also produces operators outside a chain.
        while (queued_requests.size() < N_RANDOM_REQS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_req(TYPE_W'($urandom_range(0, 15)), pick_operand());
            end
            else
            begin
                add_req(OP_LOAD, pick_operand());
                n_ops = $urandom_range(1, 8);
                repeat (n_ops)
                    add_req(TYPE_W'($urandom_range(OP_ADD, OP_POW)), pick_operand());
                if ($urandom_range(0, 2) == 0)
                begin
                    // Reload a small value half the time so the factorial is nontrivial.
                    if ($urandom_range(0, 1) == 0)
                    begin
                        small_n = $urandom_range(0, 45) - 5;
                        add_req(OP_LOAD, DATA_W'(small_n));
                    end
                    add_req(OP_FACT, pick_operand());
                end
                else
                begin
                    add_req(OP_EQUALS, pick_operand());
                end
            end
        end
        total_reqs = queued_requests.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_accepts < total_reqs)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        // Any stray response after the last one is caught by the monitor here.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d chains closed, %0d arithmetic errors, %0d sequence errors.",
                 total_reqs, chains_closed, arith_errors, seq_errors);
        $display("Checked %0d responses across %0d long receiver hold-offs; %0d mismatches.",
                 answers_seen, holds_done, fail_count);
        if (fail_count == 0)
            $display("** chained_integer_calculator_top: PASSED **");
        else
            $display("** chained_integer_calculator_top: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every request a worst-case pow with
    // the longest gaps on both sides, plus the hold-offs).
    initial
    begin
        #30_000_000;
        $display("** chained_integer_calculator_top: FAILED **");
        $finish;
    end

endmodule
